// ===== rtl/core/dlfc_pkg.sv =====
package dlfc_pkg;

    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned EV_W    = 4;
    localparam int unsigned IN_W    = 16;
    localparam int unsigned OUT_W   = 32;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned CFG_W   = 32;

    localparam logic [DUTY_W-1:0] FULL_DUTY_RST  = 8'd80;
    localparam logic [DUTY_W-1:0] RISE_TICKS_RST = 8'd3;
    localparam logic [DUTY_W-1:0] FALL_TICKS_RST = 8'd6;

    localparam logic [1:0] REG_FULL_DUTY  = 2'd0;
    localparam logic [1:0] REG_RISE_TICKS = 2'd1;
    localparam logic [1:0] REG_FALL_TICKS = 2'd2;

    localparam logic [EV_W-1:0] EV_20_TO_100 = 4'd1;
    localparam logic [EV_W-1:0] EV_20_TO_80  = 4'd2;
    localparam logic [EV_W-1:0] EV_20_TO_40  = 4'd3;
    localparam logic [EV_W-1:0] EV_40_TO_20  = 4'd4;
    localparam logic [EV_W-1:0] EV_40_TO_60  = 4'd5;
    localparam logic [EV_W-1:0] EV_60_TO_20  = 4'd6;
    localparam logic [EV_W-1:0] EV_60_TO_40  = 4'd7;
    localparam logic [EV_W-1:0] EV_60_TO_80  = 4'd8;
    localparam logic [EV_W-1:0] EV_80_TO_20  = 4'd9;
    localparam logic [EV_W-1:0] EV_80_TO_40  = 4'd10;
    localparam logic [EV_W-1:0] EV_80_TO_60  = 4'd11;
    localparam logic [EV_W-1:0] EV_100_TO_20 = 4'd12;

    typedef enum logic [1:0] {
        ST_OFF  = 2'd0,
        ST_ON   = 2'd1,
        ST_RISE = 2'd2,
        ST_FALL = 2'd3
    } t_lamp_st;

    typedef struct packed {
        t_lamp_st st;
        logic     man;
        logic     clr;
        logic     fill;
    } t_door_res;

    typedef struct packed {
        t_lamp_st          st;
        logic              man;
        logic [DUTY_W-1:0] duty;
        logic [DUTY_W-1:0] level;
        logic [TICK_W-1:0] tc;
    } t_ramp_res;

endpackage

// ===== rtl/core/door_lamp_fade_controller.sv =====
// A result item is registered when its input item is accepted. Throughput: one item
// per cycle unless m_tready stalls a full output register; the lamp state, fade
// level and tick counter update in the same cycle as the accept, so each item sees
// the previous one. Reset: synchronous, active low; lamps off, level and counter
// zero, held duties zero, registers at their defaults, output register empty.
module door_lamp_fade_controller
    import dlfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // door_event[3:0], tick[4], lamp_select[5], source_manual[6], new_status[8:7]
    input  logic [IN_W-1:0]   s_tdata,
    // func[0]
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // duty_one[7:0], duty_two[15:8], state_one[17:16], state_two[19:18],
    // ramp_level[27:20]
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    logic [DUTY_W-1:0] r_full;
    logic [DUTY_W-1:0] r_rise;
    logic [DUTY_W-1:0] r_fall;
    t_lamp_st          r_st1, r_st2;
    logic              r_man1, r_man2;
    logic [DUTY_W-1:0] r_level;
    logic [TICK_W-1:0] r_tc;
    logic [DUTY_W-1:0] r_duty1, r_duty2;
    logic              r_m_tvalid;
    logic [OUT_W-1:0]  r_m_tdata;

    t_lamp_st          n_st1, n_st2;
    logic              n_man1, n_man2;
    logic [DUTY_W-1:0] n_level;
    logic [TICK_W-1:0] n_tc;
    logic [DUTY_W-1:0] n_duty1, n_duty2;

    logic              s_accept;
    logic              cfg_wr;
    logic [EV_W-1:0]   ev;
    logic              tick;
    logic              sel;
    logic              src_man;
    t_lamp_st          status;
    logic [TICK_W-1:0] tc_inc;
    logic [DUTY_W-1:0] lvl_d;
    logic [TICK_W-1:0] tc_d;
    t_door_res         d1, d2;
    t_ramp_res         rp1, rp2;

    function automatic t_door_res door_lamp(input logic [EV_W-1:0] e, input t_lamp_st st,
                                            input logic man);
        t_door_res r;
        r.st   = st;
        r.man  = man;
        r.clr  = 1'b0;
        r.fill = 1'b0;
        if (e inside {EV_20_TO_100, EV_20_TO_40, EV_60_TO_40, EV_80_TO_40}) begin
            if (st == ST_OFF) begin
                r.st  = ST_ON;
                r.man = 1'b0;
            end
        end else if (e inside {EV_20_TO_80, EV_60_TO_80}) begin
            if (st == ST_OFF) begin
                r.st  = ST_RISE;
                r.man = 1'b0;
                r.clr = 1'b1;
            end
        end else if (e inside {EV_40_TO_20, EV_80_TO_20, EV_100_TO_20}) begin
            if (st == ST_ON && !man) begin
                r.st = ST_OFF;
            end
        end else if (e == EV_40_TO_60) begin
            if (st == ST_ON && !man) begin
                r.st   = ST_FALL;
                r.fill = 1'b1;
            end
        end else if (e == EV_80_TO_60) begin
            if ((st == ST_ON || st == ST_RISE) && !man) begin
                r.st   = ST_FALL;
                r.fill = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_ramp_res ramp_lamp(input t_lamp_st st, input logic man,
                                            input logic [DUTY_W-1:0] duty,
                                            input logic [DUTY_W-1:0] level,
                                            input logic [TICK_W-1:0] tc,
                                            input logic may_step, input logic incl,
                                            input logic [DUTY_W-1:0] full,
                                            input logic [DUTY_W-1:0] rise,
                                            input logic [DUTY_W-1:0] fall);
        t_ramp_res r;
        r.st    = st;
        r.man   = man;
        r.duty  = duty;
        r.level = level;
        r.tc    = tc;
        case (st)
            ST_RISE: begin
                if (may_step && tc > {{(TICK_W-DUTY_W){1'b0}}, rise}) begin
                    if (level != {DUTY_W{1'b1}}) begin
                        r.level = level + {{(DUTY_W-1){1'b0}}, 1'b1};
                    end
                    r.tc = '0;
                end
                if (r.level < full || (incl && r.level == full)) begin
                    r.duty = r.level;
                end else begin
                    r.level = full;
                    r.st    = ST_ON;
                    r.man   = 1'b0;
                end
            end
            ST_FALL: begin
                if (may_step && tc > {{(TICK_W-DUTY_W){1'b0}}, fall}) begin
                    if (level != '0) begin
                        r.level = level - {{(DUTY_W-1){1'b0}}, 1'b1};
                    end
                    r.tc = '0;
                end
                if (r.level != '0) begin
                    r.duty = r.level;
                end else begin
                    r.st  = ST_OFF;
                    r.man = 1'b0;
                end
            end
            ST_ON: begin
                r.duty = full;
            end
            default: begin
                r.duty = '0;
            end
        endcase
        return r;
    endfunction

    assign s_tready = !r_m_tvalid || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    assign ev      = s_tdata[3:0];
    assign tick    = s_tdata[4];
    assign sel     = s_tdata[5];
    assign src_man = s_tdata[6];
    assign status  = t_lamp_st'(s_tdata[8:7]);

    always_comb begin
        case (paddr[3:2])
            REG_FULL_DUTY:  prdata = {{(CFG_W-DUTY_W){1'b0}}, r_full};
            REG_RISE_TICKS: prdata = {{(CFG_W-DUTY_W){1'b0}}, r_rise};
            REG_FALL_TICKS: prdata = {{(CFG_W-DUTY_W){1'b0}}, r_fall};
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        tc_inc = r_tc;
        if (tick && r_tc != {TICK_W{1'b1}}) begin
            tc_inc = r_tc + {{(TICK_W-1){1'b0}}, 1'b1};
        end
        d1    = door_lamp(ev, r_st1, r_man1);
        d2    = door_lamp(ev, r_st2, r_man2);
        lvl_d = r_level;
        tc_d  = tc_inc;
        if (d1.clr || d2.clr) begin
            lvl_d = '0;
            tc_d  = '0;
        end
        if (d1.fill || d2.fill) begin
            lvl_d = r_full;
            tc_d  = '0;
        end
        rp1 = ramp_lamp(d1.st, d1.man, r_duty1, lvl_d, tc_d, 1'b1, 1'b1,
                        r_full, r_rise, r_fall);
        rp2 = ramp_lamp(d2.st, d2.man, r_duty2, rp1.level, rp1.tc, rp1.st != d2.st, 1'b0,
                        r_full, r_rise, r_fall);

        if (s_tuser) begin
            n_st1   = sel ? r_st1 : status;
            n_man1  = sel ? r_man1 : src_man;
            n_st2   = sel ? status : r_st2;
            n_man2  = sel ? src_man : r_man2;
            n_level = r_level;
            n_tc    = tc_inc;
            n_duty1 = r_duty1;
            n_duty2 = r_duty2;
        end else begin
            n_st1   = rp1.st;
            n_man1  = rp1.man;
            n_st2   = rp2.st;
            n_man2  = rp2.man;
            n_level = rp2.level;
            n_tc    = rp2.tc;
            n_duty1 = rp1.duty;
            n_duty2 = rp2.duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= FULL_DUTY_RST;
            r_rise     <= RISE_TICKS_RST;
            r_fall     <= FALL_TICKS_RST;
            r_st1      <= ST_OFF;
            r_st2      <= ST_OFF;
            r_man1     <= 1'b0;
            r_man2     <= 1'b0;
            r_level    <= '0;
            r_tc       <= '0;
            r_duty1    <= '0;
            r_duty2    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_FULL_DUTY:  r_full <= pwdata[DUTY_W-1:0];
                    REG_RISE_TICKS: r_rise <= pwdata[DUTY_W-1:0];
                    REG_FALL_TICKS: r_fall <= pwdata[DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                r_st1      <= n_st1;
                r_st2      <= n_st2;
                r_man1     <= n_man1;
                r_man2     <= n_man2;
                r_level    <= n_level;
                r_tc       <= n_tc;
                r_duty1    <= n_duty1;
                r_duty2    <= n_duty2;
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_tdata <= {4'b0000, n_level, n_st2, n_st1, n_duty2, n_duty1};
        end
    end

`ifndef SYNTHESIS
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_accept |=> $stable(r_level) && $stable(r_tc) && $stable(r_st1) && $stable(r_st2))
        else $error("lamp state changed without an item");

    a_direct_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_tuser |=> r_level == $past(r_level) && r_duty1 == $past(r_duty1)
            && r_duty2 == $past(r_duty2))
        else $error("direct set changed level or duty");

    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_m_tvalid && r_m_tdata[27:20] == r_level)
        else $error("result missing or level mismatch");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dlfc_pkg::*;

    localparam logic [EV_W-1:0] EV_NONE      = 4'd0;
    localparam logic [EV_W-1:0] EV_UNUSED_LO = 4'd13;
    localparam logic [EV_W-1:0] EV_UNUSED_HI = 4'd15;
    localparam int NUM_PLANNED = 7;
    localparam int NUM_PHASES  = 9;

    typedef struct {
        logic             func;
        logic [EV_W-1:0]  ev;
        logic             tick;
        logic             sel;
        logic             man;
        logic [1:0]       status;
    } t_step;

    typedef struct {
        logic [DUTY_W-1:0] duty_one;
        logic [DUTY_W-1:0] duty_two;
        t_lamp_st          state_one;
        t_lamp_st          state_two;
        logic [DUTY_W-1:0] level;
    } t_lamp_report;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [CFG_W-1:0]  pwdata = '0;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    door_lamp_fade_controller uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    t_step        pending_steps[$];
    t_lamp_report lamp_reports_due[$];
    int           mismatch_count = 0;
    int           steps_taken = 0;

    logic [DUTY_W-1:0] cfg_full_duty  = FULL_DUTY_RST;
    logic [DUTY_W-1:0] cfg_rise_ticks = RISE_TICKS_RST;
    logic [DUTY_W-1:0] cfg_fall_ticks = FALL_TICKS_RST;

    t_lamp_st          lamp_st [0:1]   = '{ST_OFF, ST_OFF};
    logic              lamp_man [0:1]  = '{1'b0, 1'b0};
    logic [DUTY_W-1:0] held_duty [0:1] = '{8'd0, 8'd0};
    logic [DUTY_W-1:0] fade_level = '0;
    logic [TICK_W-1:0] tick_count = '0;

    logic [DUTY_W-1:0] plan_full [NUM_PLANNED] = '{8'd80, 8'd255, 8'd0, 8'd12, 8'd200, 8'd5, 8'd1};
    logic [DUTY_W-1:0] plan_rise [NUM_PLANNED] = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0, 8'd2};
    logic [DUTY_W-1:0] plan_fall [NUM_PLANNED] = '{8'd6, 8'd0, 8'd255, 8'd2, 8'd3, 8'd0, 8'd1};

    task automatic door_change(input logic [EV_W-1:0] ev, input int k);
        case (ev)
            EV_20_TO_100, EV_20_TO_40, EV_60_TO_40, EV_80_TO_40: begin
                if (lamp_st[k] == ST_OFF) begin
                    lamp_st[k] = ST_ON;
                    lamp_man[k] = 1'b0;
                end
            end
            EV_20_TO_80, EV_60_TO_80: begin
                if (lamp_st[k] == ST_OFF) begin
                    lamp_st[k] = ST_RISE;
                    lamp_man[k] = 1'b0;
                    fade_level = '0;
                    tick_count = '0;
                end
            end
            EV_40_TO_20, EV_80_TO_20, EV_100_TO_20: begin
                if (lamp_st[k] == ST_ON && !lamp_man[k]) begin
                    lamp_st[k] = ST_OFF;
                end
            end
            EV_40_TO_60, EV_80_TO_60: begin
                if ((lamp_st[k] == ST_ON || (ev == EV_80_TO_60 && lamp_st[k] == ST_RISE))
                        && !lamp_man[k]) begin
                    lamp_st[k] = ST_FALL;
                    fade_level = cfg_full_duty;
                    tick_count = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic ramp_change(input int k, input logic may_step, input logic inclusive);
        case (lamp_st[k])
            ST_RISE: begin
                if (may_step && tick_count > cfg_rise_ticks) begin
                    if (fade_level != 8'hFF) fade_level++;
                    tick_count = '0;
                end
                if (fade_level < cfg_full_duty || (inclusive && fade_level == cfg_full_duty)) begin
                    held_duty[k] = fade_level;
                end else begin
                    fade_level = cfg_full_duty;
                    lamp_st[k] = ST_ON;
                    lamp_man[k] = 1'b0;
                end
            end
            ST_FALL: begin
                if (may_step && tick_count > cfg_fall_ticks) begin
                    if (fade_level != 8'h00) fade_level--;
                    tick_count = '0;
                end
                if (fade_level != 8'h00) begin
                    held_duty[k] = fade_level;
                end else begin
                    lamp_st[k] = ST_OFF;
                    lamp_man[k] = 1'b0;
                end
            end
            ST_ON: held_duty[k] = cfg_full_duty;
            default: held_duty[k] = '0;
        endcase
    endtask

    task automatic advance_lamps(input logic func, input logic [EV_W-1:0] ev, input logic tick,
                                 input logic sel, input logic man, input logic [1:0] status);
        t_lamp_report rpt;
        if (tick && tick_count != 16'hFFFF) tick_count++;
        if (func) begin
            lamp_st[sel] = t_lamp_st'(status);
            lamp_man[sel] = man;
        end else begin
            door_change(ev, 0);
            door_change(ev, 1);
            ramp_change(0, 1'b1, 1'b1);
            ramp_change(1, lamp_st[0] != lamp_st[1], 1'b0);
        end
        rpt.duty_one  = held_duty[0];
        rpt.duty_two  = held_duty[1];
        rpt.state_one = lamp_st[0];
        rpt.state_two = lamp_st[1];
        rpt.level     = fade_level;
        lamp_reports_due.push_back(rpt);
    endtask

    task automatic check_report(input logic [OUT_W-1:0] data);
        t_lamp_report want;
        logic [DUTY_W-1:0] got_one, got_two, got_level;
        logic [1:0] got_st_one, got_st_two;
        got_one    = data[7:0];
        got_two    = data[15:8];
        got_st_one = data[17:16];
        got_st_two = data[19:18];
        got_level  = data[27:20];
        if (lamp_reports_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected item, got duty %0d/%0d state %0d/%0d level %0d",
                         $realtime, got_one, got_two, got_st_one, got_st_two, got_level);
        end else begin
            want = lamp_reports_due.pop_front();
            if (got_one !== want.duty_one || got_two !== want.duty_two
                    || got_st_one !== want.state_one || got_st_two !== want.state_two
                    || got_level !== want.level) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: expected duty %0d/%0d state %0d/%0d level %0d,",
                             $realtime, want.duty_one, want.duty_two, want.state_one,
                             want.state_two, want.level,
                             " got duty %0d/%0d state %0d/%0d level %0d",
                             got_one, got_two, got_st_one, got_st_two, got_level);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) check_report(m_tdata);
            if (s_tvalid && s_tready) begin
                steps_taken++;
                advance_lamps(s_tuser, s_tdata[3:0], s_tdata[4], s_tdata[5], s_tdata[6],
                              s_tdata[8:7]);
            end
        end
    end

    t_step drv_step;
    int    gap_left = 0;
    int    burst_left = 1;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0 || pending_steps.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                drv_step = pending_steps.pop_front();
                s_tdata  <= {{(IN_W-9){1'b0}}, drv_step.status, drv_step.man, drv_step.sel,
                             drv_step.tick, drv_step.ev};
                s_tuser  <= drv_step.func;
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
                    gap_left   = $urandom_range(0, 6);
                end
            end
        end
    end

    int hold_left = 0;
    int window_left = 0;
    int stall_pct = 0;
    bit long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && steps_taken >= 200) begin
            long_hold_done = 1'b1;
            hold_left = 120;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 499) == 0) begin
            hold_left = $urandom_range(20, 60);
            m_tready <= 1'b0;
        end else begin
            if (window_left == 0) begin
                window_left = 64;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 70;
                endcase
            end else begin
                window_left--;
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic push_step(input logic func, input logic [EV_W-1:0] ev, input logic tick,
                             input logic sel, input logic man, input logic [1:0] status);
        t_step st;
        st.func = func;
        st.ev = ev;
        st.tick = tick;
        st.sel = sel;
        st.man = man;
        st.status = status;
        pending_steps.push_back(st);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DUTY_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FULL_DUTY:  cfg_full_duty = value;
            REG_RISE_TICKS: cfg_rise_ticks = value;
            REG_FALL_TICKS: cfg_fall_ticks = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_steps.size() != 0 || s_tvalid || lamp_reports_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_full_ramp();
        int n_rise, n_fall, j;
        n_rise = (int'(cfg_full_duty) + 2) * (int'(cfg_rise_ticks) + 1) + 4;
        n_fall = (int'(cfg_full_duty) + 2) * (int'(cfg_fall_ticks) + 1) + 4;
        if (n_rise > 50) n_rise = 50;
        if (n_fall > 50) n_fall = 50;
        push_step(1'b1, EV_NONE, 1'b0, 1'b0, 1'b0, ST_OFF);
        push_step(1'b1, EV_NONE, 1'b0, 1'b1, 1'b0, ST_OFF);
        push_step(1'b0, EV_20_TO_80, 1'b0, 1'b0, 1'b0, ST_OFF);
        for (j = 0; j < n_rise; j++)
            push_step(1'b0, EV_NONE, 1'b1, 1'($urandom), 1'($urandom), 2'($urandom));
        push_step(1'b0, EV_80_TO_60, 1'b0, 1'b0, 1'b0, ST_OFF);
        for (j = 0; j < n_fall; j++)
            push_step(1'b0, EV_NONE, 1'b1, 1'($urandom), 1'($urandom), 2'($urandom));
    endtask

    task automatic queue_random_steps(input int n);
        int done_cnt, run, j;
        logic [EV_W-1:0] ev;
        done_cnt = 0;
        while (done_cnt < n) begin
            case ($urandom_range(0, 9))
                0: begin
                    push_step(1'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
                              1'($urandom), 2'($urandom));
                    done_cnt++;
                end
                1: begin
                    push_step(1'b1, 4'($urandom), 1'($urandom), 1'($urandom),
                              1'($urandom), 2'($urandom));
                    done_cnt++;
                end
                default: begin
                    push_step(1'b0, 4'($urandom_range(1, 12)), 1'($urandom), 1'($urandom),
                              1'($urandom), 2'($urandom));
                    run = $urandom_range(1, 30);
                    for (j = 0; j < run; j++) begin
                        ev = ($urandom_range(0, 9) == 0) ? 4'($urandom) : EV_NONE;
                        push_step(1'b0, ev, $urandom_range(0, 3) != 0, 1'($urandom),
                                  1'($urandom), 2'($urandom));
                    end
                    done_cnt += run + 1;
                end
            endcase
        end
    endtask

    initial begin
        int p;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_step(1'b0, EV_20_TO_80, 1'b1, 1'b0, 1'b0, ST_OFF);
        repeat (4) push_step(1'b0, EV_NONE, 1'b1, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_80_TO_60, 1'b1, 1'b0, 1'b0, ST_OFF);
        repeat (2) push_step(1'b0, EV_NONE, 1'b1, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_40_TO_60, 1'b0, 1'b0, 1'b0, ST_OFF);
        push_step(1'b1, EV_NONE, 1'b0, 1'b0, 1'b1, ST_ON);
        push_step(1'b0, EV_80_TO_20, 1'b1, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_40_TO_60, 1'b0, 1'b0, 1'b0, ST_OFF);
        push_step(1'b1, EV_NONE, 1'b1, 1'b1, 1'b0, ST_OFF);
        push_step(1'b0, EV_20_TO_100, 1'b0, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_100_TO_20, 1'b0, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_20_TO_40, 1'b0, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_40_TO_20, 1'b0, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_60_TO_40, 1'b0, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_60_TO_20, 1'b1, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_80_TO_40, 1'b0, 1'b0, 1'b0, ST_OFF);
        push_step(1'b0, EV_60_TO_80, 1'b1, 1'b0, 1'b0, ST_OFF);
        push_step(1'b1, EV_NONE, 1'b0, 1'b0, 1'b0, ST_RISE);
        push_step(1'b0, EV_UNUSED_LO, 1'b1, 1'b1, 1'b1, ST_FALL);
        push_step(1'b0, EV_UNUSED_HI, 1'b1, 1'b1, 1'b1, ST_FALL);
        push_step(1'b1, EV_UNUSED_HI, 1'b1, 1'b1, 1'b1, ST_FALL);

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                if (p < NUM_PLANNED) begin
                    write_reg(REG_FULL_DUTY, plan_full[p]);
                    write_reg(REG_RISE_TICKS, plan_rise[p]);
                    write_reg(REG_FALL_TICKS, plan_fall[p]);
                end else begin
                    write_reg(REG_FULL_DUTY, 8'($urandom));
                    write_reg(REG_RISE_TICKS, 8'($urandom_range(0, 7)));
                    write_reg(REG_FALL_TICKS, 8'($urandom_range(0, 7)));
                end
            end
            queue_full_ramp();
            queue_random_steps(80);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
